### rtl/hps_pkg.sv
// Shared types and constants for the heading PD steering block.
// Used by hps_ser_mul, hps_ser_div and heading_pd_steer_top; no dependencies.
`default_nettype none

package hps_pkg;

    // Angle constants in hundredths of a degree and the Q4.12 unit.
    localparam int HALF_TURN   = 18000;
    localparam int FULL_TURN   = 36000;
    localparam int NEAR_PHASES = 4;
    localparam int Q_ONE       = 4096;
    localparam int Q_FRAC      = 12;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_KP_NEAR     = 3'd0;
    localparam logic [2:0] CFG_KD_NEAR     = 3'd1;
    localparam logic [2:0] CFG_KP_FAR      = 3'd2;
    localparam logic [2:0] CFG_KD_FAR      = 3'd3;
    localparam logic [2:0] CFG_GAIN_SLOPE  = 3'd4;
    localparam logic [2:0] CFG_DEAD_ZONE   = 3'd5;
    localparam logic [2:0] CFG_DRIVE_LIMIT = 3'd6;

    // Operand widths of the four serial multipliers (A is parallel, B is serial).
    localparam int M1_A_W = 16;  // |slope|
    localparam int M1_B_W = 15;  // |error|
    localparam int M2_A_W = 16;  // |kp|
    localparam int M2_B_W = 17;  // |gain multiplier|
    localparam int M3_A_W = 20;  // |effective kp|
    localparam int M3_B_W = 16;  // |error|
    localparam int M4_A_W = 16;  // |kd|
    localparam int M4_B_W = 16;  // |error difference|

    // Divider by the half turn: dividend, quotient and remainder widths.
    localparam int DIVD_W = M1_A_W + M1_B_W;
    localparam int QUOT_W = 16;
    localparam int REM_W  = DIVD_W - QUOT_W;

    // Width of the signed PD sum before scaling.
    localparam int SUM_W = M3_A_W + M3_B_W + 1;

    // Input beat and result beat.
    typedef struct packed {
        logic signed [15:0] target_heading;
        logic signed [15:0] measured_heading;
        logic        [3:0]  phase;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
    } t_out_beat;

    // Control of a serial arithmetic unit: load operands, or advance one bit.
    typedef struct packed {
        logic load;
        logic step;
    } t_ser_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL1,
        S_DIV,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/hps_ser_mul.sv
// Bit-serial shift-add multiplier for unsigned operands, one multiplier bit a cycle while step is set.
// Depends on hps_pkg for the control struct.
`default_nettype none

module hps_ser_mul import hps_pkg::*; #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic                 i_clk,
    input  wire t_ser_ctl             i_ctl,
    input  wire logic [A_W-1:0]       i_a,
    input  wire logic [B_W-1:0]       i_b,
    output logic      [A_W+B_W-1:0]   o_prod
);

    logic [A_W-1:0] r_a;
    logic [A_W-1:0] r_hi;
    logic [B_W-1:0] r_lo;
    logic [A_W:0]   w_sum;

    // Partial sum: add the multiplicand when the current multiplier bit is set.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});

    // The product shifts right through hi and lo while the multiplier shifts out.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (i_ctl.step) begin
            r_hi <= w_sum[A_W:1];
            r_lo <= {w_sum[0], r_lo[B_W-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

### rtl/hps_ser_div.sv
// Restoring divider by the half turn, one quotient bit a cycle while step is set.
// Depends on hps_pkg for widths, the divisor and the control struct.
`default_nettype none

module hps_ser_div import hps_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_ser_ctl          i_ctl,
    input  wire logic [DIVD_W-1:0] i_dividend,
    output logic      [QUOT_W-1:0] o_quot
);

    localparam logic [REM_W:0] DIVISOR = (REM_W+1)'(HALF_TURN);

    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [REM_W:0]    w_trial;
    logic [REM_W:0]    w_diff;
    logic              w_ge;

    // Bring down the next dividend bit and try a subtraction.
    assign w_trial = {r_rem, r_quot[QUOT_W-1]};
    assign w_ge    = (w_trial >= DIVISOR);
    assign w_diff  = w_trial - DIVISOR;

    // The upper dividend bits are below the divisor, so only the low bits
    // need a step; they shift out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem  <= i_dividend[DIVD_W-1:QUOT_W];
            r_quot <= i_dividend[QUOT_W-1:0];
        end else if (i_ctl.step) begin
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

### rtl/heading_pd_steer_top.sv
// Top level of the heading PD steering block: sequencer, registers and datapath.
// Depends on hps_pkg, hps_ser_mul and hps_ser_div.
//
// Usage:
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one beat with a
// target heading, a measured heading and a task phase. The output channel
// (o_out_valid, i_out_stall, o_out_data) returns one beat with left and right
// drive for every input beat, in order. Gains and limits are written through
// i_cfg_we, i_cfg_idx and i_cfg_data; the user must do so only while the
// block is idle, as the block itself does not enforce this. A beat outside
// the deadband goes through a bit-serial multiplier, a bit-serial divider,
// a second multiplier, then the third and fourth multipliers side by side;
// a new beat is taken only once the sequencer is idle again. A beat inside
// the deadband gives a zero result. The result sits in an output register,
// so the next beat may be accepted while the receiver stalls; the sequencer
// then holds its finished result until the register is free. A synchronous
// reset restores the register defaults, clears the stored previous error and
// empties the output register.
`default_nettype none

module heading_pd_steer_top import hps_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_beat    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_beat        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic signed [16:0] L_HALF   = 17'(HALF_TURN);
    localparam logic signed [16:0] L_FULL   = 17'(FULL_TURN);
    localparam logic [4:0]         N_MUL1   = 5'(M1_B_W);
    localparam logic [4:0]         N_DIV    = 5'(QUOT_W);
    localparam logic [4:0]         N_MUL2   = 5'(M2_B_W);
    localparam logic [4:0]         N_MUL3   = 5'(M3_B_W);
    localparam logic [3:0]         L_NEAR   = 4'(NEAR_PHASES);

    // Magnitude of a 16-bit signed value; the most negative value maps to 2^15.
    function automatic logic [15:0] abs16(input logic signed [15:0] x);
        abs16 = x[15] ? (16'd0 - x) : x;
    endfunction

    // Configuration registers.
    logic signed [15:0] r_kp_near;
    logic signed [15:0] r_kd_near;
    logic signed [15:0] r_kp_far;
    logic signed [15:0] r_kd_far;
    logic signed [15:0] r_theta;
    logic [14:0]        r_dead_zone;
    logic [14:0]        r_drive_limit;

    // Sequencer.
    t_state     r_state;
    t_state     n_state;
    logic [4:0] r_cnt;
    logic [4:0] n_cnt;
    t_ser_ctl   w_m1_ctl;
    t_ser_ctl   w_m2_ctl;
    t_ser_ctl   w_m3_ctl;
    t_ser_ctl   w_m4_ctl;
    t_ser_ctl   w_div_ctl;

    // Beat state.
    logic signed [15:0]      r_kp;
    logic signed [15:0]      r_kd;
    logic signed [15:0]      r_err;
    logic signed [15:0]      r_prev;
    logic                    r_dead;
    logic [15:0]             r_dmag;
    logic                    r_d_neg;
    logic                    r_a_neg;
    logic                    r_t3_neg;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_out_valid;
    t_out_beat               r_out;

    // Datapath nets.
    logic                    w_in_acc;
    logic                    w_out_free;
    logic signed [16:0]      w_diff;
    logic signed [16:0]      w_wrap;
    logic [15:0]             w_eabs;
    logic [14:0]             w_emag;
    logic                    w_is_dead;
    logic signed [16:0]      w_d;
    logic [16:0]             w_dabs;
    logic [DIVD_W-1:0]       w_p1;
    logic [QUOT_W-1:0]       w_quot;
    logic [QUOT_W-1:0]       w_quot_div;
    logic signed [17:0]      w_a;
    logic [17:0]             w_aabs;
    logic [M2_A_W+M2_B_W-1:0] w_p2;
    logic [M3_A_W-1:0]       w_kpe;
    logic [M3_A_W+M3_B_W-1:0] w_p3;
    logic [M4_A_W+M4_B_W-1:0] w_p4;
    logic [SUM_W-1:0]        w_t3;
    logic [SUM_W-1:0]        w_t4;
    logic [SUM_W-1:0]        w_smag;
    logic [SUM_W-Q_FRAC-2:0] w_q;
    logic [14:0]             w_sat;
    logic [15:0]             w_s;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_near     <= -16'sd2048;
            r_kd_near     <= -16'sd410;
            r_kp_far      <= -16'sd3686;
            r_kd_far      <= -16'sd950;
            r_theta       <= 16'sd0;
            r_dead_zone   <= 15'd200;
            r_drive_limit <= 15'd6000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP_NEAR:     r_kp_near     <= i_cfg_data;
                CFG_KD_NEAR:     r_kd_near     <= i_cfg_data;
                CFG_KP_FAR:      r_kp_far      <= i_cfg_data;
                CFG_KD_FAR:      r_kd_far      <= i_cfg_data;
                CFG_GAIN_SLOPE:  r_theta       <= i_cfg_data;
                CFG_DEAD_ZONE:   r_dead_zone   <= i_cfg_data[14:0];
                CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Heading error, wrapped once by a full turn when it reaches a half turn either way.
    always_comb begin
        w_diff = {i_in_data.target_heading[15], i_in_data.target_heading}
               - {i_in_data.measured_heading[15], i_in_data.measured_heading};
        if (w_diff >= L_HALF) begin
            w_wrap = w_diff - L_FULL;
        end else if (w_diff <= -L_HALF) begin
            w_wrap = w_diff + L_FULL;
        end else begin
            w_wrap = w_diff;
        end
    end

    // Error magnitude, deadband test and error difference.
    assign w_eabs    = abs16(r_err);
    assign w_emag    = w_eabs[14:0];
    assign w_is_dead = (w_emag < r_dead_zone);
    assign w_d       = {r_err[15], r_err} - {r_prev[15], r_prev};
    assign w_dabs    = w_d[16] ? (17'd0 - w_d) : w_d;

    // Gain multiplier 1 + slope*|e|/180 in Q4.12, from the divider quotient.
    assign w_quot = w_quot_div;
    assign w_a    = 18'(Q_ONE) + (r_theta[15] ? (18'd0 - {2'b00, w_quot})
                                              : {2'b00, w_quot});
    assign w_aabs = w_a[17] ? (18'd0 - w_a) : w_a;
    assign w_kpe  = w_p2[Q_FRAC+M3_A_W-1:Q_FRAC];

    // Signed PD terms and their sum.
    assign w_t3 = r_t3_neg ? (SUM_W'(0) - {1'b0, w_p3}) : {1'b0, w_p3};
    assign w_t4 = (r_kd[15] ^ r_d_neg) ? (SUM_W'(0) - {5'b0, w_p4}) : {5'b0, w_p4};

    // Scale toward zero, saturate on the magnitude, restore the sign.
    always_comb begin
        w_smag = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
        w_q    = w_smag[SUM_W-2:Q_FRAC];
        if (w_q > {9'd0, r_drive_limit}) begin
            w_sat = r_drive_limit;
        end else begin
            w_sat = w_q[14:0];
        end
        if (r_dead) begin
            w_s = 16'd0;
        end else if (r_sum[SUM_W-1]) begin
            w_s = 16'd0 - {1'b0, w_sat};
        end else begin
            w_s = {1'b0, w_sat};
        end
    end

    // Serial units.
    hps_ser_mul #(.A_W(M1_A_W), .B_W(M1_B_W)) u_mul1 (
        .i_clk  (i_clk),
        .i_ctl  (w_m1_ctl),
        .i_a    (abs16(r_theta)),
        .i_b    (w_emag),
        .o_prod (w_p1)
    );

    hps_ser_div u_div (
        .i_clk      (i_clk),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_p1),
        .o_quot     (w_quot_div)
    );

    hps_ser_mul #(.A_W(M2_A_W), .B_W(M2_B_W)) u_mul2 (
        .i_clk  (i_clk),
        .i_ctl  (w_m2_ctl),
        .i_a    (abs16(r_kp)),
        .i_b    (w_aabs[16:0]),
        .o_prod (w_p2)
    );

    hps_ser_mul #(.A_W(M3_A_W), .B_W(M3_B_W)) u_mul3 (
        .i_clk  (i_clk),
        .i_ctl  (w_m3_ctl),
        .i_a    (w_kpe),
        .i_b    ({1'b0, w_emag}),
        .o_prod (w_p3)
    );

    hps_ser_mul #(.A_W(M4_A_W), .B_W(M4_B_W)) u_mul4 (
        .i_clk  (i_clk),
        .i_ctl  (w_m4_ctl),
        .i_a    (abs16(r_kd)),
        .i_b    (r_dmag),
        .o_prod (w_p4)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and unit control; each serial state loads at count zero and
    // steps until the count reaches the unit's length.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        w_m1_ctl  = '0;
        w_m2_ctl  = '0;
        w_m3_ctl  = '0;
        w_m4_ctl  = '0;
        w_div_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_cnt   = 5'd0;
                n_state = w_is_dead ? S_DONE : S_MUL1;
            end
            S_MUL1: begin
                w_m1_ctl.load = (r_cnt == 5'd0);
                w_m1_ctl.step = (r_cnt != 5'd0);
                if (r_cnt == N_MUL1) begin
                    n_cnt   = 5'd0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DIV: begin
                w_div_ctl.load = (r_cnt == 5'd0);
                w_div_ctl.step = (r_cnt != 5'd0);
                if (r_cnt == N_DIV) begin
                    n_cnt   = 5'd0;
                    n_state = S_MUL2;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_MUL2: begin
                w_m2_ctl.load = (r_cnt == 5'd0);
                w_m2_ctl.step = (r_cnt != 5'd0);
                if (r_cnt == N_MUL2) begin
                    n_cnt   = 5'd0;
                    n_state = S_MUL3;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_MUL3: begin
                w_m3_ctl.load = (r_cnt == 5'd0);
                w_m3_ctl.step = (r_cnt != 5'd0);
                w_m4_ctl.load = (r_cnt == 5'd0);
                w_m4_ctl.step = (r_cnt != 5'd0);
                if (r_cnt == N_MUL3) begin
                    n_cnt   = 5'd0;
                    n_state = S_SUM;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SUM: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Beat capture, gain selection and intermediate signs.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err <= w_wrap[15:0];
            if (i_in_data.phase < L_NEAR) begin
                r_kp <= r_kp_near;
                r_kd <= r_kd_near;
            end else begin
                r_kp <= r_kp_far;
                r_kd <= r_kd_far;
            end
        end
        if (r_state == S_EVAL) begin
            r_dead  <= w_is_dead;
            r_dmag  <= w_dabs[15:0];
            r_d_neg <= w_d[16];
        end
        if (w_m2_ctl.load) begin
            r_a_neg <= w_a[17];
        end
        if (w_m3_ctl.load) begin
            r_t3_neg <= r_kp[15] ^ r_a_neg ^ r_err[15];
        end
        if (r_state == S_SUM) begin
            r_sum <= w_t3 + w_t4;
        end
    end

    // Previous error, updated only outside the deadband.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 16'sd0;
        end else if ((r_state == S_EVAL) && !w_is_dead) begin
            r_prev <= r_err;
        end
    end

    // Output register: loads the finished beat, empties when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.right_drive <= w_s;
            r_out.left_drive  <= 16'd0 - w_s;
        end
    end

`ifndef ASSERT_OFF
    // A beat taken at the input keeps the input stalled while it is worked on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after a beat was accepted");

    // The previous error moves only in the evaluation step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_prev != $past(r_prev))) |-> ($past(r_state) == S_EVAL))
        else $error("previous error changed outside evaluation");

    // A new result appears only when the sequencer finishes a beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("output valid rose without a finished beat");

    // Left drive is the negation of right drive whenever the output is valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.left_drive == 16'(16'd0 - o_out_data.right_drive)))
        else $error("left drive is not the negation of right drive");
`endif

endmodule

`default_nettype wire
